// File: hw/rtl/susi_pkg.sv
// shared types and constants for the sorted set insert block
package susi_pkg;

  localparam int ValueW  = 32;
  localparam int OpW     = 2;
  localparam int IndexW  = 6;
  localparam int StatusW = 3;
  localparam int CountW  = 7;

  // request opcodes, the fourth code changes nothing and reports done
  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_DONE      = 3'd4
  } status_t;

  // outcome of the shared comparator
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

// File: hw/rtl/susi_ram.sv
// generic single write, single read ram with registered read data
module susi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/susi_cmp.sv
// shared signed comparator used by the search walk
module susi_cmp
  import susi_pkg::*;
(
  input  logic signed [ValueW-1:0] entry,
  input  logic signed [ValueW-1:0] probe,
  output cmp_res_t                 res
);

  // two's complement order
  assign res.lt = entry < probe;
  assign res.eq = entry == probe;

endmodule

// File: hw/rtl/sorted_unique_set_insert.sv
// top level of the sorted set insert block: sequencer, entry count and result register
// Holds up to CAPACITY signed 32-bit entries in ascending order in a ram, one request
// at a time. An insert runs a binary search over the held entries with one shared
// comparator, each probe an address state S_SRCH and a compare state S_CMP because the
// ram read is registered, then shifts the entries from the insert position up one place
// at one ram write per cycle. A duplicate or full insert skips the shift. A read passes
// through S_READ to S_RESP; a clear, an unused opcode or a bad index goes straight to
// S_RESP. The table needs no clearing pass after reset; only the entry count is cleared.
// in_stall is high from acceptance until the result is loaded into the output register,
// and the result register frees the input side while a result waits. cfg_ready is always
// high.
module sorted_unique_set_insert
  import susi_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [OpW-1:0]            in_op,
  input  logic signed [ValueW-1:0]  in_value,
  input  logic [IndexW-1:0]         in_index,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [StatusW-1:0]        out_status,
  output logic signed [ValueW-1:0]  out_read_value,
  output logic [CountW-1:0]         out_count,
  // configuration write
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_allow_duplicates
);

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IXW = (CW > IndexW) ? CW : IndexW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SRCH,
    S_CMP,
    S_DECIDE,
    S_SHIFT,
    S_PLACE,
    S_RESP
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      allow_r, allow_nxt;
  logic signed [ValueW-1:0]  v_r, v_nxt;
  logic [CW-1:0]             lo_r, lo_nxt;
  logic [CW-1:0]             hi_r, hi_nxt;
  logic [AW-1:0]             mid_r, mid_nxt;
  logic                      eq_r, eq_nxt;
  logic [CW-1:0]             left_r, left_nxt;
  logic [AW-1:0]             src_r, src_nxt;
  logic [AW-1:0]             dst_r, dst_nxt;
  logic                      pend_r, pend_nxt;
  status_t                   res_status_r, res_status_nxt;
  logic signed [ValueW-1:0]  res_read_r, res_read_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [StatusW-1:0]        out_status_r, out_status_nxt;
  logic signed [ValueW-1:0]  out_read_r, out_read_nxt;
  logic [CountW-1:0]         out_count_r, out_count_nxt;

  logic                      in_accept;
  logic                      slot_free;
  logic [IXW-1:0]            idx_ext;
  logic [CW:0]               mid_sum;
  logic [AW-1:0]             mid_calc;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [ValueW-1:0]         ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [ValueW-1:0]         ram_rdata;
  cmp_res_t                  cmp;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_r;
  assign out_count      = out_count_r;

  assign idx_ext  = IXW'(in_index);
  assign mid_sum  = (CW + 1)'(lo_r) + (CW + 1)'(hi_r);
  assign mid_calc = AW'(mid_sum >> 1);

  // entry table
  susi_ram #(
    .WIDTH(ValueW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (1'b1),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // shared comparator, entry against the value being inserted
  susi_cmp u_cmp (
    .entry(ram_rdata),
    .probe(v_r),
    .res  (cmp)
  );

  // ram address and write selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dst_r;
    ram_wdata = ram_rdata;
    ram_raddr = AW'(idx_ext);
    case (state_r)
      S_SRCH: begin
        ram_raddr = mid_calc;
      end
      S_SHIFT: begin
        ram_raddr = src_r;
        ram_we    = pend_r;
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(lo_r);
        ram_wdata = v_r;
      end
      default: begin
        ram_raddr = AW'(idx_ext);
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    allow_nxt      = allow_r;
    v_nxt          = v_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    eq_nxt         = eq_r;
    left_nxt       = left_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    pend_nxt       = 1'b0;
    res_status_nxt = res_status_r;
    res_read_nxt   = res_read_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_read_nxt   = out_read_r;
    out_count_nxt  = out_count_r;

    // configuration write
    if (cfg_valid) begin
      allow_nxt = cfg_allow_duplicates;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          v_nxt        = in_value;
          res_read_nxt = '0;
          state_nxt    = S_RESP;
          case (in_op)
            OP_INSERT: begin
              lo_nxt    = '0;
              hi_nxt    = count_r;
              eq_nxt    = 1'b0;
              state_nxt = S_SRCH;
            end
            OP_READ: begin
              if (idx_ext < IXW'(count_r)) begin
                state_nxt = S_READ;
              end else begin
                res_status_nxt = ST_BAD_INDEX;
              end
            end
            OP_CLEAR: begin
              count_nxt      = '0;
              res_status_nxt = ST_DONE;
            end
            default: begin
              res_status_nxt = ST_DONE;
            end
          endcase
        end
      end
      // read data back from the ram
      S_READ: begin
        res_read_nxt   = ram_rdata;
        res_status_nxt = ST_DONE;
        state_nxt      = S_RESP;
      end
      // binary search for the first entry not smaller than the value
      S_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_calc;
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_CMP: begin
        if (cmp.lt) begin
          lo_nxt = CW'(mid_r) + CW'(1);
        end else begin
          hi_nxt = CW'(mid_r);
          eq_nxt = cmp.eq;
        end
        state_nxt = S_SRCH;
      end
      // lo holds the insert position, eq tells whether that entry matches
      S_DECIDE: begin
        if (eq_r && !allow_r) begin
          res_status_nxt = ST_DUPLICATE;
          state_nxt      = S_RESP;
        end else if (count_r == CW'(CAPACITY)) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_RESP;
        end else begin
          left_nxt  = count_r - lo_r;
          src_nxt   = AW'(count_r - CW'(1));
          state_nxt = S_SHIFT;
        end
      end
      // move entries up one place, top first, read then write
      S_SHIFT: begin
        if (left_r != '0) begin
          pend_nxt = 1'b1;
          dst_nxt  = src_r + AW'(1);
          src_nxt  = src_r - AW'(1);
          left_nxt = left_r - CW'(1);
        end else if (!pend_r) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        count_nxt      = count_r + CW'(1);
        res_status_nxt = ST_INSERTED;
        state_nxt      = S_RESP;
      end
      // hand the result to the output register
      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_read_nxt   = res_read_r;
          out_count_nxt  = CountW'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      allow_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      allow_r     <= allow_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    v_r          <= v_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    eq_r         <= eq_nxt;
    left_r       <= left_nxt;
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    res_status_r <= res_status_nxt;
    res_read_r   <= res_read_nxt;
    out_status_r <= out_status_nxt;
    out_read_r   <= out_read_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

// File: hw/rtl/susi_chk.sv
// port level checker for the sorted set insert block, with its bind
module susi_chk
  import susi_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [OpW-1:0]           in_op,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [StatusW-1:0]       out_status,
  input logic signed [ValueW-1:0] out_read_value,
  input logic [CountW-1:0]        out_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_count)
      && $stable(out_read_value))
    else $error("stalled result changed");

  // an accepted insert keeps the sequencer busy
  a_insert_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op == OP_INSERT |=> in_stall)
    else $error("insert did not occupy the sequencer");

  // only a result with status done, as a completed read gives, may carry data
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_read_value == '0)
    else $error("read value not zero");

  // a successful insert leaves at least one entry
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_INSERTED |-> out_count != '0)
    else $error("insert reported an empty table");

endmodule

bind sorted_unique_set_insert susi_chk u_susi_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_op         (in_op),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_read_value(out_read_value),
  .out_count     (out_count)
);
